FILE: rtl/core/smsq_pkg.sv
// Shared widths, constants, codes and types of the soil moisture sample qualifier.
`timescale 1ns / 1ps

package smsq_pkg;

    // Converter and field widths
    localparam int ADC_BITS   = 12;
    localparam int ADC_FULL   = (1 << ADC_BITS) - 1;
    localparam int TIME_W     = 32;
    localparam int PCT_W      = 15;
    localparam int GAIN_W     = 9;
    localparam int MIN_W      = 4;
    localparam int COUNT_W    = 16;
    localparam int RUN_W      = 8;
    localparam int STATUS_W   = 3;

    // Stream word widths (fields packed from bit 0, padded to whole bytes)
    localparam int IN_DATA_W  = ((ADC_BITS + TIME_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((STATUS_W + 1 + PCT_W + 1 + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [PCT_W-1:0]   PCT_FULL  = PCT_W'(25600);
    localparam logic [GAIN_W-1:0]  GAIN_ONE  = GAIN_W'(256);
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [RUN_W-1:0]   RUN_MAX   = {RUN_W{1'b1}};
    localparam logic [RUN_W-1:0]   STABLE_RUN_NEEDED = RUN_W'(3);

    // Percent conversion: floor(raw * 25600 / ADC_FULL) as a multiply by a
    // rounded-up reciprocal; the shift keeps the error below one step.
    localparam int PCT_SHIFT  = 2 * ADC_BITS + 2;
    localparam int PCT_MULT_W = PCT_SHIFT + 7;
    localparam int PCT_PROD_W = ADC_BITS + PCT_MULT_W;
    localparam logic [PCT_MULT_W-1:0] PCT_MULT = PCT_MULT_W'(
        ((64'd25600 << PCT_SHIFT) + 64'(ADC_FULL) - 64'd1) / 64'(ADC_FULL));

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_MS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_LOW      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_HIGH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DRY_FLOOR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ACCEPTED = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_STABLE_DELTA = 3'd7;

    // Register reset values
    localparam logic [TIME_W-1:0]   RST_WARMUP_MS    = TIME_W'(15000);
    localparam logic [ADC_BITS-1:0] RST_RAW_LOW      = ADC_BITS'(20);
    localparam logic [ADC_BITS-1:0] RST_RAW_HIGH     = ADC_BITS'(4075);
    localparam logic [PCT_W-1:0]    RST_DRY_FLOOR    = PCT_W'(256);
    localparam logic [PCT_W-1:0]    RST_MAX_STEP     = PCT_W'(8960);
    localparam logic [GAIN_W-1:0]   RST_GAIN         = GAIN_W'(90);
    localparam logic [MIN_W-1:0]    RST_MIN_ACCEPTED = MIN_W'(3);
    localparam logic [ADC_BITS-1:0] RST_STABLE_DELTA = ADC_BITS'(61);

    // Status codes
    localparam logic [STATUS_W-1:0] ST_WARMUP   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DRY      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_JUMP     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SETTLING = 3'd4;
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd5;

    typedef struct packed {
        logic [TIME_W-1:0]   warmup_ms;
        logic [ADC_BITS-1:0] raw_low_limit;
        logic [ADC_BITS-1:0] raw_high_limit;
        logic [PCT_W-1:0]    dry_floor;
        logic [PCT_W-1:0]    max_step;
        logic [GAIN_W-1:0]   smoothing_gain;
        logic [MIN_W-1:0]    min_accepted;
        logic [ADC_BITS-1:0] stable_delta;
    } t_cfg;

    // Word held between conversion and judgment
    typedef struct packed {
        logic                valid;
        logic                warming;
        logic                outside_window;
        logic [ADC_BITS-1:0] raw;
        logic [PCT_W-1:0]    percent;
    } t_stage;

    typedef struct packed {
        logic                stable;
        logic [PCT_W-1:0]    smoothed;
        logic                reading_valid;
        logic [STATUS_W-1:0] status;
    } t_result;

endpackage

FILE: rtl/core/smsq_cfg_regs.sv
// Configuration register bank with a valid/ready write channel.
`timescale 1ns / 1ps

module smsq_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [smsq_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [smsq_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output smsq_pkg::t_cfg                   o_cfg
);

    smsq_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.warmup_ms      <= smsq_pkg::RST_WARMUP_MS;
            r_cfg.raw_low_limit  <= smsq_pkg::RST_RAW_LOW;
            r_cfg.raw_high_limit <= smsq_pkg::RST_RAW_HIGH;
            r_cfg.dry_floor      <= smsq_pkg::RST_DRY_FLOOR;
            r_cfg.max_step       <= smsq_pkg::RST_MAX_STEP;
            r_cfg.smoothing_gain <= smsq_pkg::RST_GAIN;
            r_cfg.min_accepted   <= smsq_pkg::RST_MIN_ACCEPTED;
            r_cfg.stable_delta   <= smsq_pkg::RST_STABLE_DELTA;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                smsq_pkg::CFG_WARMUP_MS: begin
                    r_cfg.warmup_ms <= i_cfg_data[smsq_pkg::TIME_W-1:0];
                end
                smsq_pkg::CFG_RAW_LOW: begin
                    r_cfg.raw_low_limit <= i_cfg_data[smsq_pkg::ADC_BITS-1:0];
                end
                smsq_pkg::CFG_RAW_HIGH: begin
                    r_cfg.raw_high_limit <= i_cfg_data[smsq_pkg::ADC_BITS-1:0];
                end
                smsq_pkg::CFG_DRY_FLOOR: begin
                    r_cfg.dry_floor <= i_cfg_data[smsq_pkg::PCT_W-1:0];
                end
                smsq_pkg::CFG_MAX_STEP: begin
                    r_cfg.max_step <= i_cfg_data[smsq_pkg::PCT_W-1:0];
                end
                smsq_pkg::CFG_GAIN: begin
                    r_cfg.smoothing_gain <= i_cfg_data[smsq_pkg::GAIN_W-1:0];
                end
                smsq_pkg::CFG_MIN_ACCEPTED: begin
                    r_cfg.min_accepted <= i_cfg_data[smsq_pkg::MIN_W-1:0];
                end
                smsq_pkg::CFG_STABLE_DELTA: begin
                    r_cfg.stable_delta <= i_cfg_data[smsq_pkg::ADC_BITS-1:0];
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/smsq_convert.sv
// Input stage: raw-to-percent conversion and the state-free checks, registered.
`timescale 1ns / 1ps

module smsq_convert (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic                            i_ready,
    input  logic [smsq_pkg::ADC_BITS-1:0]   i_raw,
    input  logic [smsq_pkg::TIME_W-1:0]     i_time,
    input  smsq_pkg::t_cfg                  i_cfg,
    output smsq_pkg::t_stage                o_stage
);

    logic [smsq_pkg::PCT_PROD_W-1:0] w_prod;
    logic [smsq_pkg::PCT_W-1:0]      w_quot;
    logic [smsq_pkg::PCT_W-1:0]      w_percent;

    logic                            r_valid;
    logic                            r_warming;
    logic                            r_outside_window;
    logic [smsq_pkg::ADC_BITS-1:0]   r_raw;
    logic [smsq_pkg::PCT_W-1:0]      r_percent;

    assign w_prod = smsq_pkg::PCT_PROD_W'(i_raw) * smsq_pkg::PCT_PROD_W'(smsq_pkg::PCT_MULT);
    assign w_quot = w_prod[smsq_pkg::PCT_SHIFT +: smsq_pkg::PCT_W];
    // full-scale reading maps to zero percent
    assign w_percent = (w_quot >= smsq_pkg::PCT_FULL) ? '0 : (smsq_pkg::PCT_FULL - w_quot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && i_ready) begin
            r_warming        <= (i_time < i_cfg.warmup_ms);
            r_outside_window <= (i_raw <= i_cfg.raw_low_limit) ||
                                (i_raw >= i_cfg.raw_high_limit);
            r_raw            <= i_raw;
            r_percent        <= w_percent;
        end
    end

    assign o_stage.valid          = r_valid;
    assign o_stage.warming        = r_warming;
    assign o_stage.outside_window = r_outside_window;
    assign o_stage.raw            = r_raw;
    assign o_stage.percent        = r_percent;

endmodule

FILE: rtl/core/smsq_judge.sv
// Judgment stage: qualification state, average, stability tracking, result register.
`timescale 1ns / 1ps

module smsq_judge (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_out_load,
    input  smsq_pkg::t_stage  i_stage,
    input  smsq_pkg::t_cfg    i_cfg,
    output logic              o_out_valid,
    output smsq_pkg::t_result o_result
);

    localparam int PROD_W = smsq_pkg::PCT_W + smsq_pkg::GAIN_W + 2;
    localparam int INC_W  = PROD_W - 8;

    logic                            w_move;

    logic                            r_out_valid;
    logic [smsq_pkg::STATUS_W-1:0]   r_status;
    logic [smsq_pkg::PCT_W-1:0]      r_avg;
    logic [smsq_pkg::PCT_W-1:0]      r_last;
    logic                            r_seen;
    logic [smsq_pkg::COUNT_W-1:0]    r_count;
    logic [smsq_pkg::ADC_BITS-1:0]   r_prev;
    logic                            r_prev_known;
    logic [smsq_pkg::RUN_W-1:0]      r_run;
    logic                            r_stable;

    logic [smsq_pkg::STATUS_W-1:0]   n_status;
    logic [smsq_pkg::PCT_W-1:0]      n_avg;
    logic [smsq_pkg::PCT_W-1:0]      n_last;
    logic                            n_seen;
    logic [smsq_pkg::COUNT_W-1:0]    n_count;
    logic [smsq_pkg::ADC_BITS-1:0]   n_prev;
    logic                            n_prev_known;
    logic [smsq_pkg::RUN_W-1:0]      n_run;
    logic                            n_stable;

    logic [smsq_pkg::PCT_W-1:0]      w_step;
    logic                            w_jump;
    logic [smsq_pkg::COUNT_W-1:0]    w_count_inc;
    logic [smsq_pkg::GAIN_W-1:0]     w_gain;
    logic signed [smsq_pkg::PCT_W:0] w_avg_diff;
    logic signed [PROD_W-1:0]        w_avg_prod;
    logic signed [INC_W-1:0]         w_avg_inc;
    logic signed [INC_W-1:0]         w_avg_sum;
    logic [smsq_pkg::PCT_W-1:0]      w_avg_new;
    logic [smsq_pkg::ADC_BITS-1:0]   w_raw_diff;
    logic                            w_valid_now;
    logic [smsq_pkg::RUN_W-1:0]      w_run_next;

    assign w_move = i_out_load && i_stage.valid;

    // jump from the last accepted percent, only once enough samples were taken
    assign w_step = (i_stage.percent > r_last) ? (i_stage.percent - r_last)
                                               : (r_last - i_stage.percent);
    assign w_jump = r_seen &&
                    (r_count >= smsq_pkg::COUNT_W'(i_cfg.min_accepted)) &&
                    (w_step > i_cfg.max_step);

    assign w_count_inc = (r_count == smsq_pkg::COUNT_MAX) ? r_count : (r_count + 1'b1);

    // exponential average, increment floored toward minus infinity
    assign w_gain     = (i_cfg.smoothing_gain > smsq_pkg::GAIN_ONE) ? smsq_pkg::GAIN_ONE
                                                                    : i_cfg.smoothing_gain;
    assign w_avg_diff = $signed({1'b0, i_stage.percent}) - $signed({1'b0, r_avg});
    assign w_avg_prod = w_avg_diff * $signed({1'b0, w_gain});
    assign w_avg_inc  = $signed(w_avg_prod[PROD_W-1:8]);
    assign w_avg_sum  = $signed({{(INC_W - smsq_pkg::PCT_W){1'b0}}, r_avg}) + w_avg_inc;

    always_comb begin
        priority if (w_avg_sum < 0) begin
            w_avg_new = '0;
        end else if (w_avg_sum > $signed(INC_W'(smsq_pkg::PCT_FULL))) begin
            w_avg_new = smsq_pkg::PCT_FULL;
        end else begin
            w_avg_new = w_avg_sum[smsq_pkg::PCT_W-1:0];
        end
    end

    assign w_raw_diff = (i_stage.raw > r_prev) ? (i_stage.raw - r_prev)
                                               : (r_prev - i_stage.raw);
    assign w_run_next = (w_raw_diff > i_cfg.stable_delta) ? smsq_pkg::RUN_W'(1) :
                        (r_run == smsq_pkg::RUN_MAX)       ? r_run : (r_run + 1'b1);

    always_comb begin
        n_status     = r_status;
        n_avg        = r_avg;
        n_last       = r_last;
        n_seen       = r_seen;
        n_count      = r_count;
        n_prev       = i_stage.raw;
        n_prev_known = 1'b1;
        n_run        = r_run;
        n_stable     = r_stable;

        priority if (i_stage.warming) begin
            n_status = smsq_pkg::ST_WARMUP;
        end else if (i_stage.outside_window) begin
            n_status = smsq_pkg::ST_RANGE;
        end else if (i_stage.percent <= i_cfg.dry_floor) begin
            n_status = smsq_pkg::ST_DRY;
        end else if (w_jump) begin
            n_status = smsq_pkg::ST_JUMP;
        end else begin
            n_last   = i_stage.percent;
            n_seen   = 1'b1;
            n_avg    = r_seen ? w_avg_new : i_stage.percent;
            n_count  = w_count_inc;
            n_status = (w_count_inc < smsq_pkg::COUNT_W'(i_cfg.min_accepted))
                       ? smsq_pkg::ST_SETTLING : smsq_pkg::ST_OK;
        end

        w_valid_now = (n_status == smsq_pkg::ST_OK);

        priority if (!w_valid_now) begin
            n_run    = '0;
            n_stable = 1'b0;
        end else if (!r_prev_known) begin
            n_run    = smsq_pkg::RUN_W'(1);
            n_stable = 1'b0;
        end else begin
            n_run    = w_run_next;
            n_stable = (w_run_next >= smsq_pkg::STABLE_RUN_NEEDED);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_avg        <= '0;
            r_last       <= '0;
            r_seen       <= 1'b0;
            r_count      <= '0;
            r_prev       <= '0;
            r_prev_known <= 1'b0;
            r_run        <= '0;
            r_stable     <= 1'b0;
        end else begin
            if (i_out_load) begin
                r_out_valid <= i_stage.valid;
            end
            if (w_move) begin
                r_avg        <= n_avg;
                r_last       <= n_last;
                r_seen       <= n_seen;
                r_count      <= n_count;
                r_prev       <= n_prev;
                r_prev_known <= n_prev_known;
                r_run        <= n_run;
                r_stable     <= n_stable;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_status <= n_status;
        end
    end

    // average and stable flag change only when a word enters the result register
    assign o_out_valid            = r_out_valid;
    assign o_result.status        = r_status;
    assign o_result.reading_valid = (r_status == smsq_pkg::ST_OK);
    assign o_result.smoothed      = r_avg;
    assign o_result.stable        = r_stable;

endmodule

FILE: rtl/core/soil_moisture_sample_qualifier.sv
// Soil moisture sample qualifier, top level.
// A result word passes through the input register and then the result register, which
// loads it once the result register is empty or its word leaves.
// Throughput: one word per cycle while the result stream is not stalled; the input
// register and the result register form a two-stage pipeline; judgment state loops back.
// Reset: synchronous, active low; clears all qualification state and restores the
// register defaults. No clearing pass; words are taken from the first cycle after reset.
`timescale 1ns / 1ps

module soil_moisture_sample_qualifier (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [11:0] raw_reading, [43:12] time_ms, [47:44] zero
    input  logic [smsq_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // result stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [2:0] status_code, [3] reading_valid, [18:4] smoothed_percent,
    // [19] reading_stable, [23:20] zero
    output logic [smsq_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [smsq_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [smsq_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    smsq_pkg::t_cfg    w_cfg;
    smsq_pkg::t_stage  w_stage;
    smsq_pkg::t_result w_result;
    logic              w_out_valid;
    logic              w_out_load;

    // The result register takes a new word when empty or when its word leaves.
    // The input register advances whenever its word can move on or it is empty,
    // so a new word is taken while a finished result waits downstream if it is empty.
    assign w_out_load = !w_out_valid || i_m_tready;
    assign o_s_tready = !w_stage.valid || w_out_load;

    smsq_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // Stage one: percent conversion by reciprocal multiply, warm-up and range checks.
    smsq_convert u_convert (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_ready (o_s_tready),
        .i_raw   (i_s_tdata[smsq_pkg::ADC_BITS-1:0]),
        .i_time  (i_s_tdata[smsq_pkg::ADC_BITS +: smsq_pkg::TIME_W]),
        .i_cfg   (w_cfg),
        .o_stage (w_stage)
    );

    // Stage two: dry and jump checks, average update, count, stability run.
    smsq_judge u_judge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_out_load  (w_out_load),
        .i_stage     (w_stage),
        .i_cfg       (w_cfg),
        .o_out_valid (w_out_valid),
        .o_result    (w_result)
    );

    assign o_m_tvalid = w_out_valid;
    assign o_m_tdata  = smsq_pkg::OUT_DATA_W'(w_result);

`ifndef NO_ASSERTIONS
    // a held stage-one word with a stalled result must block the input
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_stage.valid && w_out_valid && !i_m_tready) |-> !o_s_tready)
        else $error("input taken while both pipeline stages are full");

    // a stable reading is only ever reported on a valid reading
    a_stable_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[19]) |-> o_m_tdata[3])
        else $error("reading_stable set without reading_valid");

    // the average never leaves the percent range
    a_avg_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[18:4] <= smsq_pkg::PCT_FULL))
        else $error("smoothed_percent above full scale");

    // a word that enters stage two shows up as a result in the next cycle
    a_stage_to_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_stage.valid && w_out_load) |=> o_m_tvalid)
        else $error("stage-one word lost on its way to the result register");
`endif

endmodule
